[hw/rtl/i2c_master_register_sequencer_unit_defines.svh]
// Assertion macros shared by the sequencer checkers.
`ifndef I2C_MASTER_REGISTER_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_REGISTER_SEQUENCER_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define MRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sequencer check failed");

// Clocked assertion that also holds while reset is asserted.
`define MRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sequencer check failed");

`endif

[hw/rtl/i2c_mrs_pkg.sv]
// Types, codes and status constants for the I2C register sequencer.
`default_nettype none
package i2c_mrs_pkg;

  localparam int CountWidth = 8;
  localparam int InDataW    = 64;
  localparam int OutDataW   = 40;

  // phase codes; failing phase reports the same value
  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhStart   = 3'd1;
  localparam logic [2:0] PhSlaW    = 3'd2;
  localparam logic [2:0] PhSub     = 3'd3;
  localparam logic [2:0] PhRestart = 3'd4;
  localparam logic [2:0] PhSlaR    = 3'd5;
  localparam logic [2:0] PhWData   = 3'd6;
  localparam logic [2:0] PhRData   = 3'd7;

  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActStart   = 3'd1,
    ActSend    = 3'd2,
    ActRxAck   = 3'd3,
    ActRxNack  = 3'd4,
    ActStop    = 3'd5,
    ActDisable = 3'd6
  } action_e;

  localparam logic [7:0] StMaskStart  = 8'hF8;
  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StRstart     = 8'h10;
  localparam logic [7:0] StSlaWAck    = 8'h18;
  localparam logic [7:0] StDataTxAck  = 8'h28;
  localparam logic [7:0] StSlaRAck    = 8'h40;
  localparam logic [7:0] StDataRxAck  = 8'h50;
  localparam logic [7:0] StDataRxNack = 8'h58;

  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  tx_data;
    logic [7:0]  rx_data;
    logic [7:0]  bus_status;
    logic [7:0]  byte_count;
    logic [1:0]  sub_addr_bytes;
    logic [15:0] sub_addr;
    logic [6:0]  dev_addr;
    logic        is_read;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] pad;
    logic       busy_res;
    logic [7:0] fail_status;
    logic [2:0] fail_phase;
    logic       failed;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] tx_byte;
    action_e    action;
  } out_beat_t;

endpackage
`default_nettype wire

[hw/rtl/i2c_master_register_sequencer_unit.sv]
// Top level: I2C master register read/write sequencer.
// An accepted beat passes the input register, then the result register.
// Throughput: one beat per cycle unless the output stalls; the phase decode and
// status compare between the two registers is the only logic on the item path.
// Reset (rst_ni low, async): phase to idle, transaction fields cleared, both
// register stages emptied.
`default_nettype none
module i2c_master_register_sequencer_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output      logic                             s_axis_tready_o,
  // is_read, dev_addr[7], sub_addr[16], sub_addr_bytes[2], byte_count[8],
  // bus_status[8], rx_data[8], tx_data[8], zero pad
  input  wire logic [i2c_mrs_pkg::InDataW-1:0]  s_axis_tdata_i,
  // req_type: 0 begin, 1 status report
  input  wire logic                             s_axis_tuser_i,
  output      logic                             m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // action[3], tx_byte[8], rx_valid, rx_byte[8], done_res, failed,
  // fail_phase[3], fail_status[8], busy_res, zero pad
  output      logic [i2c_mrs_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import i2c_mrs_pkg::*;

  localparam int CntExt = (CountWidth > 8) ? CountWidth : 8;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // input register stage
  in_beat_t in_q;
  logic     in_req_q;
  logic     in_valid_q;

  // result register stage
  out_beat_t out_q, out_d;
  logic      out_valid_q;

  // transaction state
  logic [2:0]            phase_q, phase_d;
  logic                  read_dir_q, read_dir_d;
  logic [6:0]            device_q, device_d;
  logic [15:0]           subaddr_q, subaddr_d;
  logic [1:0]            sub_left_q, sub_left_d;
  logic [CountWidth-1:0] bytes_left_q, bytes_left_d;

  logic                  advance;
  logic [7:0]            st, st_masked, addr_w;
  logic                  start_ok;
  logic [CntExt-1:0]     n_ext;
  logic [CountWidth-1:0] bytes_dec;

  // result stage frees up when empty or its beat is taken
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign st        = in_q.bus_status;
  assign st_masked = st & StMaskStart;
  assign start_ok  = (st_masked == StStart) || (st_masked == StRstart);
  assign addr_w    = {device_q, 1'b0};
  assign n_ext     = CntExt'(in_q.byte_count);
  assign bytes_dec = bytes_left_q - CountWidth'(1);

  always_comb begin
    phase_d      = phase_q;
    read_dir_d   = read_dir_q;
    device_d     = device_q;
    subaddr_d    = subaddr_q;
    sub_left_d   = sub_left_q;
    bytes_left_d = bytes_left_q;
    out_d        = '0;

    if (!in_req_q) begin
      // begin: taken only when idle, else dropped
      if (phase_q == PhIdle) begin
        read_dir_d   = in_q.is_read;
        device_d     = in_q.dev_addr;
        subaddr_d    = in_q.sub_addr;
        sub_left_d   = in_q.sub_addr_bytes[1] ? 2'd2 : in_q.sub_addr_bytes;
        bytes_left_d = (n_ext > CntExt'(CountMax)) ? CountMax : CountWidth'(n_ext);
        out_d.action = ActStart;
        phase_d      = PhStart;
      end
    end else begin
      case (phase_q)
        PhStart, PhRestart: begin
          if (!start_ok) begin
            out_d.action      = ActDisable;
            out_d.failed      = 1'b1;
            out_d.fail_phase  = phase_q;
            out_d.fail_status = st_masked;
            phase_d           = PhIdle;
          end else if (phase_q == PhRestart || (read_dir_q && sub_left_q == 2'd0)) begin
            out_d.action  = ActSend;
            out_d.tx_byte = addr_w | 8'h01;
            phase_d       = PhSlaR;
          end else begin
            out_d.action  = ActSend;
            out_d.tx_byte = addr_w;
            phase_d       = PhSlaW;
          end
        end
        PhSlaW, PhSub, PhWData: begin
          if (st != ((phase_q == PhSlaW) ? StSlaWAck : StDataTxAck)) begin
            out_d.action      = ActDisable;
            out_d.failed      = 1'b1;
            out_d.fail_phase  = phase_q;
            out_d.fail_status = st;
            phase_d           = PhIdle;
          end else if (phase_q != PhWData && sub_left_q != 2'd0) begin
            // high byte first when two remain
            out_d.action  = ActSend;
            out_d.tx_byte = (sub_left_q == 2'd2) ? subaddr_q[15:8] : subaddr_q[7:0];
            sub_left_d    = sub_left_q - 2'd1;
            phase_d       = PhSub;
          end else if (phase_q != PhWData && read_dir_q) begin
            out_d.action = ActStart;
            phase_d      = PhRestart;
          end else if (bytes_left_q != '0) begin
            out_d.action  = ActSend;
            out_d.tx_byte = in_q.tx_data;
            bytes_left_d  = bytes_dec;
            phase_d       = PhWData;
          end else begin
            out_d.action   = ActStop;
            out_d.done_res = 1'b1;
            phase_d        = PhIdle;
          end
        end
        PhSlaR: begin
          if (st != StSlaRAck) begin
            out_d.action      = ActDisable;
            out_d.failed      = 1'b1;
            out_d.fail_phase  = phase_q;
            out_d.fail_status = st;
            phase_d           = PhIdle;
          end else if (bytes_left_q == '0) begin
            out_d.action   = ActStop;
            out_d.done_res = 1'b1;
            phase_d        = PhIdle;
          end else begin
            out_d.action = (bytes_left_q == CountWidth'(1)) ? ActRxNack : ActRxAck;
            phase_d      = PhRData;
          end
        end
        PhRData: begin
          if (st != ((bytes_left_q == CountWidth'(1)) ? StDataRxNack : StDataRxAck)) begin
            out_d.action      = ActDisable;
            out_d.failed      = 1'b1;
            out_d.fail_phase  = phase_q;
            out_d.fail_status = st;
            phase_d           = PhIdle;
          end else begin
            out_d.rx_valid = 1'b1;
            out_d.rx_byte  = in_q.rx_data;
            bytes_left_d   = bytes_dec;
            if (bytes_dec == '0) begin
              out_d.action   = ActStop;
              out_d.done_res = 1'b1;
              phase_d        = PhIdle;
            end else begin
              out_d.action = (bytes_dec == CountWidth'(1)) ? ActRxNack : ActRxAck;
            end
          end
        end
        default: begin
          // status report while idle: nothing to do
          phase_d = PhIdle;
        end
      endcase
    end

    out_d.busy_res = (phase_d != PhIdle);
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q     <= in_beat_t'(s_axis_tdata_i);
      in_req_q <= s_axis_tuser_i;
    end
  end

  // transaction state, updated as each beat moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      read_dir_q   <= 1'b0;
      device_q     <= '0;
      subaddr_q    <= '0;
      sub_left_q   <= '0;
      bytes_left_q <= '0;
    end else if (advance) begin
      phase_q      <= phase_d;
      read_dir_q   <= read_dir_d;
      device_q     <= device_d;
      subaddr_q    <= subaddr_d;
      sub_left_q   <= sub_left_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_q);

endmodule
`default_nettype wire

[hw/rtl/i2c_mrs_checker.sv]
// Port-level checker for the I2C register sequencer, with its bind.
`default_nettype none
`include "i2c_master_register_sequencer_unit_defines.svh"
module i2c_mrs_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             m_axis_tvalid_o,
  input wire logic                             m_axis_tready_i,
  input wire logic [i2c_mrs_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import i2c_mrs_pkg::*;

  out_beat_t beat;
  assign beat = out_beat_t'(m_axis_tdata_o);

  // a stalled result beat keeps its contents
  `MRS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // end of a transaction leaves the block idle
  `MRS_ASSERT(a_end_idle, clk_i, rst_ni, m_axis_tvalid_o && (beat.done_res || beat.failed) |-> !beat.busy_res && !(beat.done_res && beat.failed))

  // abort goes with disable and a named phase, nothing else does
  `MRS_ASSERT(a_fail_code, clk_i, rst_ni, m_axis_tvalid_o |-> (beat.failed == (beat.action == ActDisable)) && (beat.failed == (beat.fail_phase != PhIdle)))

  // a delivered byte comes with the next receive or the stop
  `MRS_ASSERT(a_rx_action, clk_i, rst_ni, m_axis_tvalid_o && beat.rx_valid |-> beat.action == ActRxAck || beat.action == ActRxNack || beat.action == ActStop)

  // nothing shows on the output while in reset
  `MRS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind i2c_master_register_sequencer_unit i2c_mrs_checker u_i2c_mrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

[tb/sv/i2c_master_register_sequencer_unit_tb.sv]
// Self-checking stream testbench for the I2C master register read/write sequencer.
`timescale 1ns / 1ps
module i2c_master_register_sequencer_unit_tb;
  import i2c_mrs_pkg::*;

  localparam int         CountMax  = (1 << CountWidth) - 1;
  localparam int         CycleCap  = 200000;  // generous run limit in clock cycles
  localparam int         DrainWait = 20;      // settle time after the last result
  localparam int         HoldAt    = 150;     // result count that triggers the long hold
  localparam int         HoldLen   = 400;     // cycles of the long output hold
  localparam logic [7:0] StAllZero = 8'h00;   // fails in every phase, ignored when idle
  localparam logic [7:0] StAllOne  = 8'hFF;

  // One pending input beat; wait_idle makes the sender hold it back until
  // every outstanding result has come out.
  typedef struct {
    logic     req;
    in_beat_t beat;
    bit       wait_idle;
  } pend_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  // input side, driven with nonblocking assignments at the rising edge
  logic     in_valid  = 1'b0;
  logic     in_req    = 1'b0;
  in_beat_t in_beat   = '0;
  logic     out_ready = 1'b0;

  logic                s_tready;
  logic                m_tvalid;
  logic [OutDataW-1:0] m_tdata;

  pend_t     pend_q[$];
  out_beat_t expect_q[$];
  bit        drain_next = 1'b0;

  int err_cnt   = 0;
  int beats_in  = 0;
  int beats_out = 0;
  int done_cnt  = 0;
  int abort_cnt = 0;
  int rx_cnt    = 0;
  int cycle_cnt = 0;

  // sequencer state as predicted from the accepted input beats
  logic [2:0]            seq_phase      = PhIdle;
  logic                  seq_read       = 1'b0;
  logic [6:0]            seq_dev        = '0;
  logic [15:0]           seq_sub        = '0;
  logic [1:0]            seq_sub_left   = '0;
  logic [CountWidth-1:0] seq_bytes_left = '0;

  i2c_master_register_sequencer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (in_beat),
    .s_axis_tuser_i  (in_req),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Sequencer prediction
  // ---------------------------------------------------------------------------

  function automatic out_beat_t send_beat(logic [7:0] byte_val, logic [2:0] next_ph);
    out_beat_t r;
    r         = '0;
    r.action  = ActSend;
    r.tx_byte = byte_val;
    seq_phase = next_ph;
    return r;
  endfunction

  // abort: engine disabled, no STOP
  function automatic out_beat_t abort_beat(logic [2:0] ph, logic [7:0] st);
    out_beat_t r;
    r             = '0;
    r.action      = ActDisable;
    r.failed      = 1'b1;
    r.fail_phase  = ph;
    r.fail_status = st;
    seq_phase     = PhIdle;
    return r;
  endfunction

  function automatic out_beat_t stop_beat();
    out_beat_t r;
    r          = '0;
    r.action   = ActStop;
    r.done_res = 1'b1;
    seq_phase  = PhIdle;
    return r;
  endfunction

  // last byte of a read gets NACK, all others ACK
  function automatic out_beat_t recv_beat();
    out_beat_t r;
    r         = '0;
    r.action  = (seq_bytes_left == 1) ? ActRxNack : ActRxAck;
    seq_phase = PhRData;
    return r;
  endfunction

  function automatic out_beat_t write_beat(logic [7:0] txd);
    if (seq_bytes_left != 0) begin
      seq_bytes_left = seq_bytes_left - 1'b1;
      return send_beat(txd, PhWData);
    end
    return stop_beat();
  endfunction

  function automatic out_beat_t predict_beat(logic req, in_beat_t b);
    out_beat_t  r;
    logic [7:0] st_m;
    logic [7:0] addr_w;
    r      = '0;
    st_m   = b.bus_status & StMaskStart;
    addr_w = {seq_dev, 1'b0};
    if (!req) begin
      // a begin only takes effect when idle
      if (seq_phase == PhIdle) begin
        seq_read       = b.is_read;
        seq_dev        = b.dev_addr;
        seq_sub        = b.sub_addr;
        seq_sub_left   = (b.sub_addr_bytes > 2'd2) ? 2'd2 : b.sub_addr_bytes;
        seq_bytes_left = (b.byte_count > CountMax) ? CountWidth'(CountMax)
                                                   : CountWidth'(b.byte_count);
        r.action       = ActStart;
        seq_phase      = PhStart;
      end
    end else begin
      case (seq_phase)
        PhStart, PhRestart: begin
          // start checks ignore the low three status bits
          if (st_m != StStart && st_m != StRstart) begin
            r = abort_beat(seq_phase, st_m);
          end else if (seq_phase == PhRestart || (seq_read && seq_sub_left == 0)) begin
            r = send_beat(addr_w | 8'h01, PhSlaR);
          end else begin
            r = send_beat(addr_w, PhSlaW);
          end
        end
        PhSlaW, PhSub: begin
          if (b.bus_status != ((seq_phase == PhSlaW) ? StSlaWAck : StDataTxAck)) begin
            r = abort_beat(seq_phase, b.bus_status);
          end else if (seq_sub_left != 0) begin
            // high byte first when two are left
            r = send_beat((seq_sub_left == 2'd2) ? seq_sub[15:8] : seq_sub[7:0], PhSub);
            seq_sub_left = seq_sub_left - 1'b1;
          end else if (seq_read) begin
            r.action  = ActStart;
            seq_phase = PhRestart;
          end else begin
            r = write_beat(b.tx_data);
          end
        end
        PhSlaR: begin
          if (b.bus_status != StSlaRAck) begin
            r = abort_beat(PhSlaR, b.bus_status);
          end else if (seq_bytes_left == 0) begin
            r = stop_beat();
          end else begin
            r = recv_beat();
          end
        end
        PhWData: begin
          if (b.bus_status != StDataTxAck) begin
            r = abort_beat(PhWData, b.bus_status);
          end else begin
            r = write_beat(b.tx_data);
          end
        end
        PhRData: begin
          if (b.bus_status != ((seq_bytes_left == 1) ? StDataRxNack : StDataRxAck)) begin
            r = abort_beat(PhRData, b.bus_status);
          end else begin
            seq_bytes_left = seq_bytes_left - 1'b1;
            if (seq_bytes_left == 0) begin
              r = stop_beat();
            end else begin
              r = recv_beat();
            end
            r.rx_valid = 1'b1;
            r.rx_byte  = b.rx_data;
          end
        end
        default: ;  // status while idle is dropped
      endcase
    end
    r.busy_res = (seq_phase != PhIdle);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b                = '0;
    b.is_read        = $urandom_range(0, 1);
    b.dev_addr       = $urandom_range(0, 127);
    b.sub_addr       = $urandom_range(0, 65535);
    b.sub_addr_bytes = $urandom_range(0, 3);
    b.byte_count     = $urandom_range(0, 255);
    b.bus_status     = $urandom_range(0, 255);
    b.rx_data        = $urandom_range(0, 255);
    b.tx_data        = $urandom_range(0, 255);
    return b;
  endfunction

  function automatic void queue_item(logic req, in_beat_t b);
    pend_t p;
    p.req       = req;
    p.beat      = b;
    p.wait_idle = drain_next;
    drain_next  = 1'b0;
    pend_q.push_back(p);
  endfunction

  // status the engine reports when the bus action went as planned
  function automatic logic [7:0] good_status(logic [2:0] ph, bit last_byte);
    case (ph)
      PhStart, PhRestart: begin
        return (($urandom_range(0, 1) != 0) ? StStart : StRstart)
               | (($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 7)) : 8'h00);
      end
      PhSlaW:         return StSlaWAck;
      PhSlaR:         return StSlaRAck;
      PhRData:        return last_byte ? StDataRxNack : StDataRxAck;
      default:        return StDataTxAck;
    endcase
  endfunction

  function automatic logic [7:0] bad_status(logic [2:0] ph, bit last_byte);
    logic [7:0] s;
    logic [7:0] s_m;
    bit         ok;
    do begin
      case ($urandom_range(0, 3))
        0:       s = StAllOne;
        1:       s = StAllZero;
        default: s = $urandom_range(0, 255);
      endcase
      s_m = s & StMaskStart;
      if (ph == PhStart || ph == PhRestart) begin
        ok = (s_m == StStart || s_m == StRstart);
      end else begin
        ok = (s == good_status(ph, last_byte));
      end
    end while (ok);
    return s;
  endfunction

  // One transaction: begin beat, then the status reports that walk it through
  // its phases. abort_at names the report that gets a wrong code (none if out
  // of range); busy_at forces an ignored begin after that report, and a negative
  // busy_at slips one in now and then.
  task automatic add_txn(input bit rd, input bit [6:0] dev, input bit [1:0] nsub,
                         input bit [7:0] nbytes, input int abort_at, input int busy_at);
    logic [2:0] steps[$];
    in_beat_t   b;
    int         n_sub;
    bit         last_rep;
    b                = rand_beat();
    b.is_read        = rd;
    b.dev_addr       = dev;
    b.sub_addr_bytes = nsub;
    b.byte_count     = nbytes;
    queue_item(1'b0, b);
    n_sub = (nsub > 2) ? 2 : nsub;
    steps.push_back(PhStart);
    if (rd && n_sub == 0) begin
      steps.push_back(PhSlaR);  // current-address read
    end else begin
      steps.push_back(PhSlaW);
      repeat (n_sub) steps.push_back(PhSub);
      if (rd) begin
        steps.push_back(PhRestart);
        steps.push_back(PhSlaR);
      end
    end
    repeat (nbytes) steps.push_back(rd ? PhRData : PhWData);
    foreach (steps[i]) begin
      last_rep     = (i == steps.size() - 1);
      b            = rand_beat();
      b.bus_status = (i == abort_at) ? bad_status(steps[i], last_rep)
                                     : good_status(steps[i], last_rep);
      queue_item(1'b1, b);
      if (i == abort_at) break;
      if (!last_rep && (i == busy_at || (busy_at < 0 && $urandom_range(0, 19) == 0))) begin
        queue_item(1'b0, rand_beat());
      end
    end
  endtask

  // Raw random beats, then an all-zero status that aborts whatever they left
  // running, so the next transaction starts from idle.
  task automatic add_noise();
    in_beat_t b;
    repeat ($urandom_range(1, 6)) queue_item($urandom_range(0, 1), rand_beat());
    b            = rand_beat();
    b.bus_status = StAllZero;
    queue_item(1'b1, b);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------

  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin : feed_proc
    pend_t p;
    logic  holding;
    if (rst_ni) begin
      holding = in_valid;
      if (in_valid && s_tready) begin
        expect_q.push_back(predict_beat(in_req, in_beat));
        beats_in++;
        holding = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
            default:    gap_left = $urandom_range(5, 30);
          endcase
        end
      end
      // a beat on offer stays until taken
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0 && (!pend_q[0].wait_idle || expect_q.size() == 0)) begin
          p = pend_q.pop_front();
          in_valid <= 1'b1;
          in_req   <= p.req;
          in_beat  <= p.beat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result beat, stalls in changing patterns
  // ---------------------------------------------------------------------------

  int sink_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : sink_proc
    out_beat_t got;
    out_beat_t want;
    if (rst_ni) begin
      if (m_tvalid && out_ready) begin
        got = m_tdata;
        if (expect_q.size() == 0) begin
          $error("result beat 0x%h arrived with no expectation pending", got);
          err_cnt++;
        end else begin
          want = expect_q.pop_front();
          check_field("action", want.action, got.action);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("rx_valid", want.rx_valid, got.rx_valid);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("done_res", want.done_res, got.done_res);
          check_field("failed", want.failed, got.failed);
          check_field("fail_phase", want.fail_phase, got.fail_phase);
          check_field("fail_status", want.fail_status, got.fail_status);
          check_field("busy_res", want.busy_res, got.busy_res);
          done_cnt  += want.done_res;
          abort_cnt += want.failed;
          rx_cnt    += want.rx_valid;
        end
        beats_out++;
      end
      // one long hold while the sender keeps offering, so the block backs up
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && beats_out >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldLen;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(32, 256);
        end else begin
          mode_left--;
        end
        case (sink_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    cycle_cnt++;
    if (cycle_cnt >= CycleCap) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stim_proc
    in_beat_t b;
    int       pick;
    bit [7:0] nb;
    bit [1:0] ns;

    // falling edge at time zero so the asynchronous reset takes hold
    rst_ni <= 1'b0;

    // status while idle: dropped
    b            = rand_beat();
    b.bus_status = StStart;
    queue_item(1'b1, b);
    // write, two sub-address bytes, one data byte, a begin while busy in between
    add_txn(1'b0, 7'h7F, 2'd2, 8'd1, -1, 2);
    // current-address read of two bytes
    add_txn(1'b1, 7'h00, 2'd0, 8'd2, -1, -2);
    // sub-address count three acts as two; read with no data bytes
    add_txn(1'b1, 7'h55, 2'd3, 8'd0, -1, -2);
    // one sub-address byte, no data: STOP right after the sub-address byte
    add_txn(1'b0, 7'h2A, 2'd1, 8'd0, -1, -2);
    // bad start status
    add_txn(1'b0, 7'h7F, 2'd0, 8'd0, 0, -2);

    // one full-length write, then a pause until the block has drained
    add_txn(1'b0, $urandom_range(0, 127), $urandom_range(0, 3), 8'hFF, -1, -1);
    drain_next = 1'b1;

    while (pend_q.size() < 780) begin
      if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        add_noise();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) nb = $urandom_range(0, 3);
        else if (pick < 90) nb = $urandom_range(4, 20);
        else if (pick < 99) nb = $urandom_range(21, 100);
        else nb = $urandom_range(128, 255);
        ns = $urandom_range(0, 3);
        add_txn($urandom_range(0, 1), $urandom_range(0, 127), ns, nb,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4 + ns + nb) : -1, -1);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Run covered %0d input beats and %0d result beats in %0d cycles.",
             beats_in, beats_out, cycle_cnt);
    $display("Transactions: %0d ended with STOP, %0d aborted; %0d read bytes delivered.",
             done_cnt, abort_cnt, rx_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
